### design/pfr_pkg.sv
// Shared types and constants for the page frame replacement block.
`timescale 1ns / 1ps

package pfr_pkg;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_FINISH = 4'b0100,
    ST_WRITE  = 4'b1000
  } state_t;

  // Result outcome codes
  localparam logic [1:0] OUT_HIT     = 2'd0;
  localparam logic [1:0] OUT_FREE    = 2'd1;
  localparam logic [1:0] OUT_REPLACE = 2'd2;
  localparam logic [1:0] OUT_CLEARED = 2'd3;

  // Input item modes
  localparam logic MODE_REF   = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // Register select (word address bit)
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_FRAMES = 1'b1;

  // Policy codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // Fixed port widths
  localparam int CFG_ADDR_W   = 3;
  localparam int CFG_DATA_W   = 32;
  localparam int FRAMES_CFG_W = 5;
  localparam int IN_PAGE_W    = 16;
  localparam int OUT_PAGE_W   = 16;
  localparam int OUT_INDEX_W  = 4;
  localparam int FAULT_W      = 32;

  localparam logic [FRAMES_CFG_W-1:0] FRAMES_RESET = 5'd16;

  // Control from sequencer to the compare unit
  typedef struct packed {
    logic init;
    logic en;
    logic policy;
  } scan_ctrl_t;

  // Status from the compare unit back to the sequencer
  typedef struct packed {
    logic hit_found;
    logic free_found;
  } scan_flags_t;

endpackage

### design/pfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

### design/pfr_scan.sv
// Shared compare unit: checks one frame per cycle for hit, free slot and oldest stamp.
`timescale 1ns / 1ps

module pfr_scan #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pfr_pkg::scan_ctrl_t       ctrl,
  input  logic [$clog2(FRAMES)-1:0] idx,
  input  logic                      entry_valid,
  input  logic [PAGE_BITS-1:0]      target_page,
  input  logic [PAGE_BITS-1:0]      entry_page,
  input  logic [TIME_BITS-1:0]      entry_arrival,
  input  logic [TIME_BITS-1:0]      entry_last_use,
  output pfr_pkg::scan_flags_t      flags,
  output logic [$clog2(FRAMES)-1:0] hit_idx,
  output logic [$clog2(FRAMES)-1:0] free_idx,
  output logic [$clog2(FRAMES)-1:0] victim_idx,
  output logic [PAGE_BITS-1:0]      victim_page
);

  localparam int IDX_W = $clog2(FRAMES);

  logic                 hit_found_r, hit_found_nxt;
  logic                 free_found_r, free_found_nxt;
  logic [IDX_W-1:0]     hit_idx_r, free_idx_r, victim_idx_r;
  logic [PAGE_BITS-1:0] victim_page_r;
  logic [TIME_BITS-1:0] best_r;
  logic [TIME_BITS-1:0] stamp;
  logic                 take_hit, take_free, take_best;

  // per-entry compares
  always_comb begin
    stamp     = (ctrl.policy == pfr_pkg::POLICY_LRU) ? entry_last_use : entry_arrival;
    take_hit  = ctrl.en && entry_valid && (entry_page == target_page) && !hit_found_r;
    take_free = ctrl.en && !entry_valid && !free_found_r;
    take_best = ctrl.en && ((idx == '0) || (stamp < best_r));
  end

  // first-match flags
  always_comb begin
    hit_found_nxt  = hit_found_r;
    free_found_nxt = free_found_r;
    if (ctrl.init) begin
      hit_found_nxt  = 1'b0;
      free_found_nxt = 1'b0;
    end else begin
      if (take_hit) begin
        hit_found_nxt = 1'b1;
      end
      if (take_free) begin
        free_found_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
    end
  end

  // tracked indexes and victim data
  always_ff @(posedge clk) begin
    if (take_hit) begin
      hit_idx_r <= idx;
    end
    if (take_free) begin
      free_idx_r <= idx;
    end
    if (take_best) begin
      best_r        <= stamp;
      victim_idx_r  <= idx;
      victim_page_r <= entry_page;
    end
  end

  assign flags.hit_found  = hit_found_r;
  assign flags.free_found = free_found_r;
  assign hit_idx          = hit_idx_r;
  assign free_idx         = free_idx_r;
  assign victim_idx       = victim_idx_r;
  assign victim_page      = victim_page_r;

endmodule

### design/page_frame_replacement.sv
// Top level: sequencer, frame stores, counters and configuration port.
//
// Fully associative page frame table with FIFO or LRU replacement.
// Input: pulse start with in_mode/in_page_number while busy is low; the item
// is taken at that edge. in_mode 0 looks up a page, 1 clears all frames and
// both counters.
// Output: one result per item, shown for exactly one cycle with out_valid
// high; the receiver cannot hold it off.
// A lookup scans the active frames one per cycle through a single compare
// unit fed by registered-read stores, then passes through the finish and
// write states before its result strobe, and start can be taken again in
// the strobe cycle.
// A clear needs no scan: its result strobe rises in the cycle after the edge.
// Config: APB-style port, register 0 (addr 0) policy, 0 FIFO / 1 LRU;
// register 1 (addr 4) frames_in_use. Write only while idle.
// Reset: frames empty, counters zero, policy LRU, 16 frames in use; the
// page and timestamp stores are not cleared since every read of them is
// gated by the frame's valid bit.
`timescale 1ns / 1ps

module page_frame_replacement #(
  parameter int FRAMES    = 16,
  parameter int PAGE_BITS = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // item channel
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic [pfr_pkg::IN_PAGE_W-1:0]     in_page_number,
  // result channel
  output logic                              out_valid,
  output logic [1:0]                        out_outcome,
  output logic [pfr_pkg::OUT_INDEX_W-1:0]   out_frame_index,
  output logic [pfr_pkg::OUT_PAGE_W-1:0]    out_evicted_page,
  output logic [pfr_pkg::FAULT_W-1:0]       out_fault_count,
  output logic                              out_time_exhausted,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pfr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [pfr_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [pfr_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int IDX_W = $clog2(FRAMES);
  localparam logic [TIME_BITS-1:0]        TIME_MAX  = '1;
  localparam logic [pfr_pkg::FAULT_W-1:0] FAULT_MAX = '1;

  pfr_pkg::state_t state_r, state_nxt;

  logic [IDX_W-1:0]                    addr_r, addr_nxt;
  logic [IDX_W-1:0]                    cmp_idx_r;
  logic                                cmp_en_r, cmp_en_nxt;
  logic [PAGE_BITS-1:0]                target_r;
  logic [FRAMES-1:0]                   valid_r, valid_nxt;
  logic [TIME_BITS-1:0]                access_r, access_nxt, access_inc;
  logic [pfr_pkg::FAULT_W-1:0]         fault_r, fault_nxt, fault_inc;
  logic                                policy_r;
  logic [pfr_pkg::FRAMES_CFG_W-1:0]    frames_r;
  logic [IDX_W-1:0]                    last_idx;

  logic                                out_valid_r, out_valid_nxt;
  logic [1:0]                          out_outcome_r, out_outcome_nxt;
  logic [pfr_pkg::OUT_INDEX_W-1:0]     out_index_r, out_index_nxt;
  logic [pfr_pkg::OUT_PAGE_W-1:0]      out_evict_r, out_evict_nxt;
  logic [pfr_pkg::FAULT_W-1:0]         out_fault_r, out_fault_nxt;
  logic                                out_exh_r, out_exh_nxt;

  logic                                accept, cfg_wr;
  logic                                page_we, arr_we, lru_we;
  logic [IDX_W-1:0]                    slot;
  logic [PAGE_BITS-1:0]                rd_page;
  logic [TIME_BITS-1:0]                rd_arrival, rd_last_use;

  pfr_pkg::scan_ctrl_t                 scan_ctrl;
  pfr_pkg::scan_flags_t                scan_flags;
  logic [IDX_W-1:0]                    hit_idx, free_idx, victim_idx;
  logic [PAGE_BITS-1:0]                victim_page;

  assign accept = start && !busy;
  assign busy   = (state_r != pfr_pkg::ST_IDLE);

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == pfr_pkg::REG_FRAMES) begin
      prdata = pfr_pkg::CFG_DATA_W'(frames_r);
    end else begin
      prdata = pfr_pkg::CFG_DATA_W'(policy_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= pfr_pkg::POLICY_LRU;
      frames_r <= pfr_pkg::FRAMES_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == pfr_pkg::REG_FRAMES) begin
        frames_r <= pwdata[pfr_pkg::FRAMES_CFG_W-1:0];
      end else begin
        policy_r <= pwdata[0];
      end
    end
  end

  // last active frame: zero acts as one, above FRAMES acts as FRAMES
  always_comb begin
    if (frames_r == '0) begin
      last_idx = '0;
    end else if (32'(frames_r) > FRAMES) begin
      last_idx = IDX_W'(FRAMES - 1);
    end else begin
      last_idx = IDX_W'(32'(frames_r) - 32'd1);
    end
  end

  // frame stores
  pfr_ram #(.WIDTH(PAGE_BITS), .DEPTH(FRAMES)) u_page_ram (
    .clk   (clk),
    .we    (page_we),
    .waddr (slot),
    .wdata (target_r),
    .raddr (addr_r),
    .rdata (rd_page)
  );

  pfr_ram #(.WIDTH(TIME_BITS), .DEPTH(FRAMES)) u_arrival_ram (
    .clk   (clk),
    .we    (arr_we),
    .waddr (slot),
    .wdata (access_r),
    .raddr (addr_r),
    .rdata (rd_arrival)
  );

  pfr_ram #(.WIDTH(TIME_BITS), .DEPTH(FRAMES)) u_last_use_ram (
    .clk   (clk),
    .we    (lru_we),
    .waddr (slot),
    .wdata (access_r),
    .raddr (addr_r),
    .rdata (rd_last_use)
  );

  // shared compare unit
  assign scan_ctrl.init   = accept;
  assign scan_ctrl.en     = cmp_en_r;
  assign scan_ctrl.policy = policy_r;

  pfr_scan #(.FRAMES(FRAMES), .PAGE_BITS(PAGE_BITS), .TIME_BITS(TIME_BITS)) u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (scan_ctrl),
    .idx            (cmp_idx_r),
    .entry_valid    (valid_r[cmp_idx_r]),
    .target_page    (target_r),
    .entry_page     (rd_page),
    .entry_arrival  (rd_arrival),
    .entry_last_use (rd_last_use),
    .flags          (scan_flags),
    .hit_idx        (hit_idx),
    .free_idx       (free_idx),
    .victim_idx     (victim_idx),
    .victim_page    (victim_page)
  );

  // chosen frame and store writes
  always_comb begin
    if (scan_flags.hit_found) begin
      slot = hit_idx;
    end else if (scan_flags.free_found) begin
      slot = free_idx;
    end else begin
      slot = victim_idx;
    end
    lru_we  = (state_r == pfr_pkg::ST_WRITE);
    page_we = lru_we && !scan_flags.hit_found;
    arr_we  = page_we;
  end

  // saturating counter increments
  assign access_inc = (access_r != TIME_MAX) ? access_r + 1'b1 : access_r;
  assign fault_inc  = (fault_r != FAULT_MAX) ? fault_r + 1'b1 : fault_r;

  // sequencer
  always_comb begin
    state_nxt       = state_r;
    addr_nxt        = addr_r;
    cmp_en_nxt      = 1'b0;
    valid_nxt       = valid_r;
    access_nxt      = access_r;
    fault_nxt       = fault_r;
    out_valid_nxt   = 1'b0;
    out_outcome_nxt = out_outcome_r;
    out_index_nxt   = out_index_r;
    out_evict_nxt   = out_evict_r;
    out_fault_nxt   = out_fault_r;
    out_exh_nxt     = out_exh_r;
    unique case (state_r)
      pfr_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_mode == pfr_pkg::MODE_CLEAR) begin
            valid_nxt       = '0;
            access_nxt      = '0;
            fault_nxt       = '0;
            out_valid_nxt   = 1'b1;
            out_outcome_nxt = pfr_pkg::OUT_CLEARED;
            out_index_nxt   = '0;
            out_evict_nxt   = '0;
            out_fault_nxt   = '0;
            out_exh_nxt     = 1'b0;
          end else begin
            addr_nxt  = '0;
            state_nxt = pfr_pkg::ST_SCAN;
          end
        end
      end
      pfr_pkg::ST_SCAN: begin
        cmp_en_nxt = 1'b1;
        if (addr_r == last_idx) begin
          state_nxt = pfr_pkg::ST_FINISH;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      pfr_pkg::ST_FINISH: begin
        state_nxt = pfr_pkg::ST_WRITE;
      end
      pfr_pkg::ST_WRITE: begin
        state_nxt     = pfr_pkg::ST_IDLE;
        access_nxt    = access_inc;
        out_valid_nxt = 1'b1;
        out_index_nxt = pfr_pkg::OUT_INDEX_W'(slot);
        out_exh_nxt   = (access_inc == TIME_MAX);
        out_evict_nxt = '0;
        if (scan_flags.hit_found) begin
          out_outcome_nxt = pfr_pkg::OUT_HIT;
          out_fault_nxt   = fault_r;
        end else begin
          valid_nxt[slot] = 1'b1;
          fault_nxt       = fault_inc;
          out_fault_nxt   = fault_inc;
          if (scan_flags.free_found) begin
            out_outcome_nxt = pfr_pkg::OUT_FREE;
          end else begin
            out_outcome_nxt = pfr_pkg::OUT_REPLACE;
            out_evict_nxt   = pfr_pkg::OUT_PAGE_W'(victim_page);
          end
        end
      end
      default: begin
        state_nxt = pfr_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfr_pkg::ST_IDLE;
      addr_r      <= '0;
      cmp_en_r    <= 1'b0;
      valid_r     <= '0;
      access_r    <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      cmp_en_r    <= cmp_en_nxt;
      valid_r     <= valid_nxt;
      access_r    <= access_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmp_idx_r     <= addr_r;
    out_outcome_r <= out_outcome_nxt;
    out_index_r   <= out_index_nxt;
    out_evict_r   <= out_evict_nxt;
    out_fault_r   <= out_fault_nxt;
    out_exh_r     <= out_exh_nxt;
    if (accept) begin
      target_r <= PAGE_BITS'(in_page_number);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_outcome        = out_outcome_r;
  assign out_frame_index    = out_index_r;
  assign out_evicted_page   = out_evict_r;
  assign out_fault_count    = out_fault_r;
  assign out_time_exhausted = out_exh_r;

  // a result is only shown once the sequencer is back in idle
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == pfr_pkg::ST_IDLE))
    else $error("result strobe outside idle");

  // a lookup item starts a scan on the next cycle
  a_lookup_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_mode == pfr_pkg::MODE_REF)) |=> (state_r == pfr_pkg::ST_SCAN))
    else $error("lookup did not start scan");

  // scan address stays within the active frames
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == pfr_pkg::ST_SCAN) |-> (addr_r <= last_idx))
    else $error("scan address beyond active frames");

  // a hit leaves the fault count unchanged
  a_hit_no_fault: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_outcome_r == pfr_pkg::OUT_HIT)) |-> $stable(fault_r))
    else $error("fault count moved on a hit");

endmodule

### dv/page_frame_replacement_tb.sv
// Self-checking testbench for the page frame replacement table: queued driver, monitor and scoreboard.
`timescale 1ns / 1ps

module page_frame_replacement_tb;

  localparam int TBL_FRAMES = 16;
  localparam logic [pfr_pkg::CFG_ADDR_W-1:0] ADDR_POLICY = 3'd0;
  localparam logic [pfr_pkg::CFG_ADDR_W-1:0] ADDR_FRAMES = 3'd4;
  localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] FAULT_SAT = 32'hFFFF_FFFF;

  typedef struct packed {
    logic        mode;
    logic [15:0] page;
    bit          hold;  // wait for the table to drain before sending
  } page_ref_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [3:0]  frame;
    logic [15:0] evicted;
    logic [31:0] faults;
    logic        exhausted;
  } frame_result_t;

  // DUT-facing signals; the ones the bench drives are known from time zero
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = pfr_pkg::MODE_REF;
  logic [pfr_pkg::IN_PAGE_W-1:0] in_page_number = '0;
  logic out_valid;
  logic [1:0] out_outcome;
  logic [pfr_pkg::OUT_INDEX_W-1:0] out_frame_index;
  logic [pfr_pkg::OUT_PAGE_W-1:0] out_evicted_page;
  logic [pfr_pkg::FAULT_W-1:0] out_fault_count;
  logic out_time_exhausted;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pfr_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [pfr_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [pfr_pkg::CFG_DATA_W-1:0] prdata;
  logic pready;

  // Predicted frame table
  logic [15:0] tbl_page [TBL_FRAMES];
  bit          tbl_valid [TBL_FRAMES];
  logic [31:0] tbl_arrive [TBL_FRAMES];
  logic [31:0] tbl_used [TBL_FRAMES];
  logic [31:0] stamp_cnt;
  logic [31:0] fault_cnt;
  logic        cur_policy;
  logic [4:0]  cur_frames;

  // Queues and bookkeeping
  page_ref_t     pending_refs[$];
  frame_result_t expected_results[$];
  int  issued = 0;
  int  accepted_count = 0;
  int  outstanding = 0;
  int  errors = 0;
  int  gap_left = 0;
  bit  idle_gaps = 1'b0;
  int  n_hit = 0, n_free = 0, n_repl = 0, n_clear = 0, n_settings = 0;
  page_ref_t nxt;

  page_frame_replacement u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_mode           (in_mode),
    .in_page_number    (in_page_number),
    .out_valid         (out_valid),
    .out_outcome       (out_outcome),
    .out_frame_index   (out_frame_index),
    .out_evicted_page  (out_evicted_page),
    .out_fault_count   (out_fault_count),
    .out_time_exhausted(out_time_exhausted),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  // Empty every frame and zero both counters
  function automatic void empty_frames();
    for (int i = 0; i < TBL_FRAMES; i++) begin
      tbl_page[i] = '0;
      tbl_valid[i] = 1'b0;
      tbl_arrive[i] = '0;
      tbl_used[i] = '0;
    end
    stamp_cnt = '0;
    fault_cnt = '0;
  endfunction

  function automatic int active_frames(logic [4:0] cfg);
    if (cfg == 5'd0) return 1;
    if (cfg > TBL_FRAMES) return TBL_FRAMES;
    return int'(cfg);
  endfunction

  // Predict one item and update the table copy
  function automatic frame_result_t lookup_frame_table(logic mode, logic [15:0] page);
    frame_result_t r;
    int n;
    int slot;
    int i;
    bit found;
    logic [31:0] now;
    logic [31:0] best;
    logic [31:0] t;
    r = '0;
    if (mode == pfr_pkg::MODE_CLEAR) begin
      empty_frames();
      r.outcome = pfr_pkg::OUT_CLEARED;
      return r;
    end
    n = active_frames(cur_frames);
    now = stamp_cnt;
    found = 1'b0;
    slot = 0;
    for (i = 0; i < n && !found; i++) begin
      if (tbl_valid[i] && tbl_page[i] == page) begin
        slot = i;
        found = 1'b1;
      end
    end
    if (found) begin
      tbl_used[slot] = now;
      r.outcome = pfr_pkg::OUT_HIT;
    end else begin
      if (fault_cnt != FAULT_SAT) fault_cnt++;
      for (i = 0; i < n && !found; i++) begin
        if (!tbl_valid[i]) begin
          slot = i;
          found = 1'b1;
        end
      end
      if (found) begin
        r.outcome = pfr_pkg::OUT_FREE;
      end else begin
        // victim: oldest stamp under the policy, ties to lowest index
        slot = 0;
        best = (cur_policy == pfr_pkg::POLICY_LRU) ? tbl_used[0] : tbl_arrive[0];
        for (i = 1; i < n; i++) begin
          t = (cur_policy == pfr_pkg::POLICY_LRU) ? tbl_used[i] : tbl_arrive[i];
          if (t < best) begin
            best = t;
            slot = i;
          end
        end
        r.outcome = pfr_pkg::OUT_REPLACE;
        r.evicted = tbl_page[slot];
      end
      tbl_valid[slot] = 1'b1;
      tbl_page[slot] = page;
      tbl_arrive[slot] = now;
      tbl_used[slot] = now;
    end
    if (stamp_cnt != STAMP_MAX) stamp_cnt++;
    r.frame = slot[3:0];
    r.faults = fault_cnt;
    r.exhausted = (stamp_cnt == STAMP_MAX);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  // Driver: holds start until taken, then, when idle gaps are on, idles for a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!(start && busy)) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_refs.size() != 0 &&
                   !(pending_refs[0].hold && (start || outstanding != 0))) begin
        nxt = pending_refs.pop_front();
        start <= 1'b1;
        in_mode <= nxt.mode;
        in_page_number <= nxt.page;
        gap_left = idle_gaps ? int'($urandom_range(0, 6)) : 0;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: check results, track register writes, predict taken items
  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      empty_frames();
      cur_policy = pfr_pkg::POLICY_LRU;
      cur_frames = pfr_pkg::FRAMES_RESET;
      expected_results.delete();
      outstanding <= 0;
      accepted_count <= 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing expected", {30'd0, out_outcome}, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_outcome !== want.outcome)
            report_mismatch("outcome", {30'd0, out_outcome}, {30'd0, want.outcome});
          if (out_frame_index !== want.frame)
            report_mismatch("frame_index", {28'd0, out_frame_index}, {28'd0, want.frame});
          if (out_evicted_page !== want.evicted)
            report_mismatch("evicted_page", {16'd0, out_evicted_page}, {16'd0, want.evicted});
          if (out_fault_count !== want.faults)
            report_mismatch("fault_count", out_fault_count, want.faults);
          if (out_time_exhausted !== want.exhausted)
            report_mismatch("time_exhausted", {31'd0, out_time_exhausted},
                            {31'd0, want.exhausted});
          unique case (want.outcome)
            pfr_pkg::OUT_HIT:     n_hit++;
            pfr_pkg::OUT_FREE:    n_free++;
            pfr_pkg::OUT_REPLACE: n_repl++;
            default:              n_clear++;
          endcase
        end
      end
      if (psel && penable && pwrite && pready) begin
        if (paddr == ADDR_POLICY) cur_policy = pwdata[0];
        else if (paddr == ADDR_FRAMES) cur_frames = pwdata[4:0];
      end
      if (start && !busy) begin
        expected_results.push_back(lookup_frame_table(in_mode, in_page_number));
        accepted_count <= accepted_count + 1;
      end
      outstanding <= expected_results.size();
    end
  end

  task automatic queue_item(logic mode, logic [15:0] page, bit hold);
    page_ref_t it;
    it.mode = mode;
    it.page = page;
    it.hold = hold;
    pending_refs.push_back(it);
    issued++;
  endtask

  // Wait until every item is taken and answered, plus a short settle
  task automatic wait_idle();
    while (accepted_count != issued || outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Two-phase register write; pready is checked in the access phase
  task automatic cfg_write(logic [pfr_pkg::CFG_ADDR_W-1:0] addr, logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    n_settings++;
  endtask

  // Random phase: mostly a small working set so hits and evictions happen
  task automatic random_phase(logic pol, logic [4:0] frames, bit gaps, int count);
    int span;
    int pick;
    logic [15:0] base;
    logic [15:0] page;
    cfg_write(ADDR_POLICY, {31'd0, pol});
    cfg_write(ADDR_FRAMES, {27'd0, frames});
    idle_gaps = gaps;
    span = active_frames(frames) + int'($urandom_range(0, 4));
    base = 16'($urandom_range(0, 65535));
    for (int k = 0; k < count; k++) begin
      pick = int'($urandom_range(0, 99));
      if (pick < 2)
        queue_item(pfr_pkg::MODE_CLEAR, 16'($urandom_range(0, 65535)),
                   1'($urandom_range(0, 1)));
      else if (pick < 12)
        queue_item(pfr_pkg::MODE_REF, 16'($urandom_range(0, 65535)),
                   $urandom_range(0, 49) == 0);
      else begin
        page = base + 16'($urandom_range(0, span - 1));
        queue_item(pfr_pkg::MODE_REF, page, $urandom_range(0, 49) == 0);
      end
    end
    wait_idle();
  endtask

  // Run limit
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Stimulus sequence
  initial begin
    logic       pol_list [9];
    logic [4:0] frm_list [9];
    pol_list = '{pfr_pkg::POLICY_LRU, pfr_pkg::POLICY_LRU, pfr_pkg::POLICY_FIFO,
                 pfr_pkg::POLICY_FIFO, pfr_pkg::POLICY_LRU, pfr_pkg::POLICY_FIFO,
                 pfr_pkg::POLICY_LRU, pfr_pkg::POLICY_FIFO, pfr_pkg::POLICY_LRU};
    frm_list = '{5'd16, 5'd1, 5'd2, 5'd16, 5'd4, 5'd0, 5'd31, 5'd8, 5'd5};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: fills, hits, a clear after a drain, refill
    idle_gaps = 1'b0;
    queue_item(pfr_pkg::MODE_REF, 16'h0000, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'hFFFF, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'h0000, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'hFFFF, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'hAAAA, 1'b0);
    queue_item(pfr_pkg::MODE_CLEAR, 16'hFFFF, 1'b1);
    queue_item(pfr_pkg::MODE_REF, 16'h5555, 1'b0);
    wait_idle();

    // One frame: every miss replaces frame zero
    cfg_write(ADDR_FRAMES, 32'd1);
    queue_item(pfr_pkg::MODE_REF, 16'h5555, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'h0001, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'h0001, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'h8000, 1'b0);
    wait_idle();

    // Three frames, FIFO: a hit does not save the oldest arrival
    cfg_write(ADDR_POLICY, {31'd0, pfr_pkg::POLICY_FIFO});
    cfg_write(ADDR_FRAMES, 32'd3);
    queue_item(pfr_pkg::MODE_REF, 16'h0010, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'h0020, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'h8000, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'h0030, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'h0010, 1'b0);
    wait_idle();

    // Same frames, LRU: evicts the least recently touched
    cfg_write(ADDR_POLICY, {31'd0, pfr_pkg::POLICY_LRU});
    queue_item(pfr_pkg::MODE_REF, 16'h0040, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'h0030, 1'b0);
    wait_idle();

    // Zero frames acts as one; upper frames keep contents
    cfg_write(ADDR_FRAMES, 32'd0);
    queue_item(pfr_pkg::MODE_REF, 16'h0050, 1'b0);
    wait_idle();

    // Out of range high acts as all frames; old frames seen again
    cfg_write(ADDR_FRAMES, 32'd31);
    queue_item(pfr_pkg::MODE_REF, 16'h0010, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'h0040, 1'b0);
    queue_item(pfr_pkg::MODE_REF, 16'h1234, 1'b0);
    wait_idle();

    for (int p = 0; p < 9; p++)
      random_phase(pol_list[p], frm_list[p], (p % 3) != 1, 72);

    repeat (24) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never received", 32'(expected_results.size()), 32'd0);
    $display("Ran %0d items: %0d hits, %0d free-frame faults, %0d replacements, %0d clears.",
             accepted_count, n_hit, n_free, n_repl, n_clear);
    $display("Register writes: %0d, FIFO and LRU, frame counts 0 to 31, random idle gaps.",
             n_settings);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
